// ===== rtl/pcud_pkg.sv =====
// ----------------------------------------------------------------------------
// pcud_pkg
// Shared types and constants of the packed code unpack and dequantize unit.
// ----------------------------------------------------------------------------
package pcud_pkg;

  // stream word and code geometry
  localparam int WORD_BITS   = 16;
  localparam int CODE_BITS   = 16;
  localparam int CARRY_BITS  = WORD_BITS - 1;
  localparam int CCNT_BITS   = 4;
  localparam int ACC_BITS    = WORD_BITS + CARRY_BITS;
  localparam int POS_BITS    = 5;
  localparam int WIDTH_BITS  = 5;

  // fixed point formats
  localparam int MIN_BITS    = 32;
  localparam int QUANT_BITS  = 32;
  localparam int PROD_BITS   = CODE_BITS + QUANT_BITS;
  localparam int VALUE_BITS  = 50;
  localparam int COUNT_BITS  = 24;

  // configuration port
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 32;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_CODE_WIDTH   = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_VALUE    = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_QUANTUM      = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_COUNT = 8'd3;

  // register reset values
  localparam logic [WIDTH_BITS-1:0] CODE_WIDTH_RST   = 5'd8;
  localparam logic [MIN_BITS-1:0]   MIN_VALUE_RST    = 32'd0;
  localparam logic [QUANT_BITS-1:0] QUANTUM_RST      = 32'd65536;
  localparam logic [COUNT_BITS-1:0] SAMPLE_COUNT_RST = 24'd0;

  // unpack sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_CUT
  } state_t;

  // one code handed from the unpacker to the dequantizer
  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic                 last_of_word;
    logic                 final_sample;
  } pcud_req_t;

  // clear requests raised by configuration writes
  typedef struct packed {
    logic clear_carry;
    logic clear_count;
  } pcud_clr_t;

endpackage

// ===== rtl/pcud_word_if.sv =====
// ----------------------------------------------------------------------------
// pcud_word_if
// Input channel carrying one packed 16-bit stream word per transaction.
// ----------------------------------------------------------------------------
interface pcud_word_if;
  import pcud_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] packed_word;

  modport source (output valid, output packed_word, input ready);
  modport sink   (input valid, input packed_word, output ready);
endinterface

// ===== rtl/pcud_result_if.sv =====
// ----------------------------------------------------------------------------
// pcud_result_if
// Output channel carrying one unpacked and dequantized code per transaction.
// ----------------------------------------------------------------------------
interface pcud_result_if;
  import pcud_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [CODE_BITS-1:0]         code;
  logic signed [VALUE_BITS-1:0] value;
  logic                         last_of_word;
  logic                         final_sample;

  modport source (output valid, output code, output value, output last_of_word,
                  output final_sample, input ready);
  modport sink   (input valid, input code, input value, input last_of_word,
                  input final_sample, output ready);
endinterface

// ===== rtl/pcud_cfg_if.sv =====
// ----------------------------------------------------------------------------
// pcud_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pcud_cfg_if;
  import pcud_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/pcud_cut.sv =====
// ----------------------------------------------------------------------------
// pcud_cut
// Unpack sequencer: holds carry and accumulator, counts emitted samples and cuts
// one code per cycle off the top with a shared shifter while requests are taken.
// ----------------------------------------------------------------------------
module pcud_cut (
  input  logic                            clk,
  input  logic                            rst,
  pcud_word_if.sink                       word_in,
  input  logic [pcud_pkg::WIDTH_BITS-1:0] code_width,
  input  logic [pcud_pkg::COUNT_BITS-1:0] sample_count,
  input  pcud_pkg::pcud_clr_t             clr,
  output logic                            req_valid,
  input  logic                            req_ready,
  output pcud_pkg::pcud_req_t             req
);
  import pcud_pkg::*;

  state_t                state;
  state_t                state_next;
  logic [ACC_BITS-1:0]   acc;
  logic [POS_BITS-1:0]   bits;
  logic [CARRY_BITS-1:0] carry_bits;
  logic [CCNT_BITS-1:0]  carry_count;
  logic [COUNT_BITS-1:0] codes_emitted;

  logic [WIDTH_BITS-1:0] width_eff;
  logic [CODE_BITS:0]    code_mask;
  logic [CARRY_BITS:0]   carry_mask;
  logic                  have_code;
  logic [POS_BITS-1:0]   bits_next;
  logic [ACC_BITS-1:0]   shifted;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  emit;
  logic                  in_fire;
  logic                  req_fire;

  // effective width, zero acts as one, above sixteen acts as sixteen
  always_comb begin
    if (code_width == '0) begin
      width_eff = WIDTH_BITS'(1);
    end else if (code_width > WIDTH_BITS'(CODE_BITS)) begin
      width_eff = WIDTH_BITS'(CODE_BITS);
    end else begin
      width_eff = code_width;
    end
  end

  // shared shifter and code extraction
  always_comb begin
    have_code  = (bits >= width_eff);
    bits_next  = bits - width_eff;
    shifted    = acc >> bits_next;
    code_mask  = ((CODE_BITS+1)'(1) << width_eff) - (CODE_BITS+1)'(1);
    carry_mask = ((CARRY_BITS+1)'(1) << bits[CCNT_BITS-1:0]) - (CARRY_BITS+1)'(1);
    count_inc  = codes_emitted + COUNT_BITS'(1);
    emit       = (codes_emitted < sample_count);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_CUT;
        end
      end
      ST_CUT: begin
        if (!have_code) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    word_in.ready    = (state == ST_IDLE);
    req_valid        = (state == ST_CUT) && have_code && emit;
    req.code         = shifted[CODE_BITS-1:0] & code_mask[CODE_BITS-1:0];
    req.final_sample = (count_inc == sample_count);
    req.last_of_word = (bits_next < width_eff) || req.final_sample;
  end

  assign in_fire  = word_in.valid && word_in.ready;
  assign req_fire = req_valid && req_ready;

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      carry_bits    <= '0;
      carry_count   <= '0;
      codes_emitted <= '0;
    end else begin
      state <= state_next;
      if ((state == ST_CUT) && !have_code) begin
        carry_bits  <= acc[CARRY_BITS-1:0] & carry_mask[CARRY_BITS-1:0];
        carry_count <= bits[CCNT_BITS-1:0];
      end
      if (req_fire) begin
        codes_emitted <= count_inc;
      end
      if (clr.clear_carry) begin
        carry_bits  <= '0;
        carry_count <= '0;
      end
      if (clr.clear_count) begin
        codes_emitted <= '0;
      end
    end
  end

  // accumulator and bit position
  always_ff @(posedge clk) begin
    if (in_fire) begin
      acc  <= {carry_bits, word_in.packed_word};
      bits <= POS_BITS'(carry_count) + POS_BITS'(WORD_BITS);
    end else if ((state == ST_CUT) && have_code && (!emit || req_ready)) begin
      bits <= bits_next;
    end
  end

endmodule

// ===== rtl/pcud_mac.sv =====
// ----------------------------------------------------------------------------
// pcud_mac
// Dequantizer: registered code times quantum, then min added into the
// output register of the result channel.
// ----------------------------------------------------------------------------
module pcud_mac (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  pcud_pkg::pcud_req_t             req,
  input  logic [pcud_pkg::MIN_BITS-1:0]   min_value,
  input  logic [pcud_pkg::QUANT_BITS-1:0] quantum,
  pcud_result_if.source                   result_out
);
  import pcud_pkg::*;

  logic                         prod_valid;
  logic [PROD_BITS-1:0]         prod;
  pcud_req_t                    prod_req;
  logic                         out_valid;
  logic [CODE_BITS-1:0]         out_code;
  logic signed [VALUE_BITS-1:0] out_value;
  logic                         out_last;
  logic                         out_final;

  logic                         advance;
  logic signed [VALUE_BITS-1:0] sum;

  // stage movement
  always_comb begin
    advance   = prod_valid && (!out_valid || result_out.ready);
    req_ready = !prod_valid || advance;
    sum       = signed'({{(VALUE_BITS-MIN_BITS){min_value[MIN_BITS-1]}}, min_value})
              + signed'({{(VALUE_BITS-PROD_BITS){1'b0}}, prod});
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        prod_valid <= 1'b1;
      end else if (advance) begin
        prod_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      prod     <= PROD_BITS'(req.code) * PROD_BITS'(quantum);
      prod_req <= req;
    end
  end

  // add stage into the output register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_code  <= prod_req.code;
      out_value <= sum;
      out_last  <= prod_req.last_of_word;
      out_final <= prod_req.final_sample;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.code         = out_code;
  assign result_out.value        = out_value;
  assign result_out.last_of_word = out_last;
  assign result_out.final_sample = out_final;

endmodule

// ===== rtl/packed_code_unpack_dequantize_unit.sv =====
// ----------------------------------------------------------------------------
// packed_code_unpack_dequantize_unit
// Unpacks MSB-first codes of 1 to 16 bits from 16-bit words and dequantizes
// each one as min_value + code * quantum in signed Q34.16.
//
// word_in takes one packed word per transaction; result_out returns one
// transaction per emitted code, with last_of_word on the final code of the
// word and final_sample on the sample_count-th code. cfg writes code_width,
// min_value, quantum and sample_count (indexes 0 to 3); writes are accepted
// every cycle and are meant for an idle block. Writing code_width restarts
// packing, writing sample_count starts a new run with the counter cleared.
// A word is accepted while idle; the single shifter then cuts one code per
// cycle while each emitted code is taken, then a last step stores the
// leftover bits as carry before the next word is accepted. A cut code is
// registered in the multiply stage, then in the add stage's output register.
// If the receiver stalls, the two result stages fill and the shifter waits.
// Reset returns the registers to 8, 0, 65536 and 0 and clears the carry.
// ----------------------------------------------------------------------------
module packed_code_unpack_dequantize_unit (
  input  logic          clk,
  input  logic          rst,
  pcud_word_if.sink     word_in,
  pcud_result_if.source result_out,
  pcud_cfg_if.sink      cfg
);
  import pcud_pkg::*;

  logic [WIDTH_BITS-1:0] code_width;
  logic [MIN_BITS-1:0]   min_value;
  logic [QUANT_BITS-1:0] quantum;
  logic [COUNT_BITS-1:0] sample_count;
  pcud_clr_t             clr;
  logic                  cfg_fire;
  logic                  req_valid;
  logic                  req_ready;
  pcud_req_t             req;

  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid && cfg.ready;

  // clear requests from configuration writes, applied at the write edge
  always_comb begin
    clr.clear_carry = cfg_fire &&
                      ((cfg.index == REG_CODE_WIDTH) || (cfg.index == REG_SAMPLE_COUNT));
    clr.clear_count = cfg_fire && (cfg.index == REG_SAMPLE_COUNT);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      code_width   <= CODE_WIDTH_RST;
      min_value    <= MIN_VALUE_RST;
      quantum      <= QUANTUM_RST;
      sample_count <= SAMPLE_COUNT_RST;
    end else if (cfg_fire) begin
      case (cfg.index)
        REG_CODE_WIDTH:   code_width   <= cfg.data[WIDTH_BITS-1:0];
        REG_MIN_VALUE:    min_value    <= cfg.data[MIN_BITS-1:0];
        REG_QUANTUM:      quantum      <= cfg.data[QUANT_BITS-1:0];
        REG_SAMPLE_COUNT: sample_count <= cfg.data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // unpack sequencer
  pcud_cut u_cut (
    .clk          (clk),
    .rst          (rst),
    .word_in      (word_in),
    .code_width   (code_width),
    .sample_count (sample_count),
    .clr          (clr),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req          (req)
  );

  // multiply and add stages
  pcud_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .min_value  (min_value),
    .quantum    (quantum),
    .result_out (result_out)
  );

endmodule

// ===== test/tb_packed_code_unpack_dequantize_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_packed_code_unpack_dequantize_unit
// Drives packed words through the unpacker and checks every code, its
// dequantized value and its flags against an in-bench unpacker that keeps its
// own carry, run counter and register copies. A directed table covers the
// extremes and the register corner cases, then random phases rewrite the
// registers and stream random words under random idle and stall.
// ----------------------------------------------------------------------------
module tb_packed_code_unpack_dequantize_unit;
  import pcud_pkg::*;

  localparam int unsigned RUN_LIMIT     = 300000;
  localparam int unsigned BLOCK_LATENCY = 32;
  localparam int unsigned RANDOM_WORDS  = 360;
  localparam int unsigned NUM_ROWS      = 43;

  typedef struct packed {
    logic [CODE_BITS-1:0]  code;
    logic [VALUE_BITS-1:0] value;
    logic                  last_of_word;
    logic                  final_sample;
  } code_sample_t;

  typedef enum logic {ROW_REG, ROW_WORD} row_e;
  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_ONE} check_e;

  typedef struct packed {
    row_e                      kind;
    check_e                    chk;
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [CFG_DATA_BITS-1:0]  data;
    code_sample_t              want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic calm;
  int unsigned cycle_count;
  int unsigned mismatches;

  code_sample_t pending_samples[$];

  // register copies and unpack state
  logic [WIDTH_BITS-1:0] m_width;
  logic [MIN_BITS-1:0]   m_min;
  logic [QUANT_BITS-1:0] m_quantum;
  logic [COUNT_BITS-1:0] m_limit;
  logic [CARRY_BITS-1:0] m_carry;
  logic [CCNT_BITS-1:0]  m_carry_n;
  logic [COUNT_BITS-1:0] m_emitted;

  pcud_word_if   word_if ();
  pcud_result_if res_if ();
  pcud_cfg_if    cfg_if ();

  packed_code_unpack_dequantize_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .word_in    (word_if),
    .result_out (res_if),
    .cfg        (cfg_if)
  );

  // directed stimulus: register writes and words, some with typed results
  stim_row_t directed_rows [NUM_ROWS] = '{
    // nothing comes out right after reset, the run length is zero
    '{ROW_WORD, EXP_NONE,  8'd0,             32'h0000_FFFF, '0},
    '{ROW_REG,  EXP_MODEL, REG_SAMPLE_COUNT, 32'hFFFF_FFFF, '0},
    '{ROW_WORD, EXP_MODEL, 8'd0,             32'h0000_A5C3, '0},
    '{ROW_REG,  EXP_MODEL, REG_CODE_WIDTH,   32'd16,        '0},
    '{ROW_WORD, EXP_ONE,   8'd0,             32'h0000_FFFF,
      '{16'hFFFF, 50'h0_FFFF_0000, 1'b1, 1'b0}},
    '{ROW_WORD, EXP_ONE,   8'd0,             32'h0000_0000,
      '{16'h0000, 50'd0, 1'b1, 1'b0}},
    // most negative minimum with the largest step
    '{ROW_REG,  EXP_MODEL, REG_MIN_VALUE,    32'h8000_0000, '0},
    '{ROW_REG,  EXP_MODEL, REG_QUANTUM,      32'hFFFF_FFFF, '0},
    '{ROW_WORD, EXP_ONE,   8'd0,             32'h0000_FFFF,
      '{16'hFFFF, 50'(-64'sd2147483648 + 64'sd65535 * 64'sd4294967295), 1'b1, 1'b0}},
    '{ROW_WORD, EXP_ONE,   8'd0,             32'h0000_0000,
      '{16'h0000, 50'(-64'sd2147483648), 1'b1, 1'b0}},
    '{ROW_REG,  EXP_MODEL, REG_MIN_VALUE,    32'h7FFF_FFFF, '0},
    '{ROW_WORD, EXP_ONE,   8'd0,             32'h0000_FFFF,
      '{16'hFFFF, 50'(64'sd2147483647 + 64'sd65535 * 64'sd4294967295), 1'b1, 1'b0}},
    // zero step leaves only the minimum
    '{ROW_REG,  EXP_MODEL, REG_QUANTUM,      32'd0,         '0},
    '{ROW_WORD, EXP_ONE,   8'd0,             32'h0000_1234,
      '{16'h1234, 50'd2147483647, 1'b1, 1'b0}},
    // one-bit codes, sixteen per word
    '{ROW_REG,  EXP_MODEL, REG_CODE_WIDTH,   32'd1,         '0},
    '{ROW_REG,  EXP_MODEL, REG_MIN_VALUE,    32'd0,         '0},
    '{ROW_REG,  EXP_MODEL, REG_QUANTUM,      32'd65536,     '0},
    '{ROW_WORD, EXP_MODEL, 8'd0,             32'h0000_A5A5, '0},
    // width zero acts as one
    '{ROW_REG,  EXP_MODEL, REG_CODE_WIDTH,   32'd0,         '0},
    '{ROW_WORD, EXP_MODEL, 8'd0,             32'h0000_5A5A, '0},
    // width above sixteen acts as sixteen
    '{ROW_REG,  EXP_MODEL, REG_CODE_WIDTH,   32'd31,        '0},
    '{ROW_WORD, EXP_ONE,   8'd0,             32'h0000_8001,
      '{16'h8001, 50'h0_8001_0000, 1'b1, 1'b0}},
    // only the low five data bits set the width, codes cross words
    '{ROW_REG,  EXP_MODEL, REG_CODE_WIDTH,   32'hFFFF_FFE5, '0},
    '{ROW_WORD, EXP_MODEL, 8'd0,             32'h0000_FFFF, '0},
    '{ROW_WORD, EXP_MODEL, 8'd0,             32'h0000_8421, '0},
    // width rewrite drops the carried bits
    '{ROW_REG,  EXP_MODEL, REG_CODE_WIDTH,   32'd5,         '0},
    '{ROW_WORD, EXP_MODEL, 8'd0,             32'h0000_1234, '0},
    '{ROW_REG,  EXP_MODEL, REG_CODE_WIDTH,   32'd3,         '0},
    '{ROW_WORD, EXP_MODEL, 8'd0,             32'h0000_6DB6, '0},
    '{ROW_WORD, EXP_MODEL, 8'd0,             32'h0000_FFFF, '0},
    '{ROW_WORD, EXP_MODEL, 8'd0,             32'h0000_0001, '0},
    '{ROW_REG,  EXP_MODEL, REG_CODE_WIDTH,   32'd7,         '0},
    '{ROW_WORD, EXP_MODEL, 8'd0,             32'h0000_1357, '0},
    // new run of five: final flag mid word, then everything is dropped
    '{ROW_REG,  EXP_MODEL, REG_SAMPLE_COUNT, 32'd5,         '0},
    '{ROW_WORD, EXP_MODEL, 8'd0,             32'h0000_FFFF, '0},
    '{ROW_WORD, EXP_MODEL, 8'd0,             32'h0000_0F0F, '0},
    '{ROW_WORD, EXP_MODEL, 8'd0,             32'h0000_F0F0, '0},
    '{ROW_WORD, EXP_NONE,  8'd0,             32'h0000_FFFF, '0},
    // indexes beyond the register file are ignored
    '{ROW_REG,  EXP_MODEL, 8'd4,             32'hDEAD_BEEF, '0},
    '{ROW_REG,  EXP_MODEL, 8'hFF,            32'h1234_5678, '0},
    // run of one
    '{ROW_REG,  EXP_MODEL, REG_SAMPLE_COUNT, 32'd1,         '0},
    '{ROW_WORD, EXP_ONE,   8'd0,             32'h0000_FE00,
      '{16'h007F, 50'h0_007F_0000, 1'b1, 1'b1}},
    '{ROW_WORD, EXP_NONE,  8'd0,             32'h0000_FFFF, '0}
  };

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic reset_copies();
    m_width   = CODE_WIDTH_RST;
    m_min     = MIN_VALUE_RST;
    m_quantum = QUANTUM_RST;
    m_limit   = SAMPLE_COUNT_RST;
    m_carry   = '0;
    m_carry_n = '0;
    m_emitted = '0;
  endtask

  // cut every completed code from carry plus word and dequantize it
  task automatic unpack_word(input logic [WORD_BITS-1:0] w, output code_sample_t cut[$]);
    int unsigned     wid;
    int unsigned     bits;
    logic [30:0]     acc;
    logic [31:0]     c;
    logic [63:0]     prod;
    longint          v;
    code_sample_t    s;
    cut = {};
    wid = (m_width == 0) ? 1 : (m_width > 16) ? 16 : int'(m_width);
    acc = {m_carry, w};
    bits = m_carry_n + 16;
    while (bits >= wid) begin
      bits -= wid;
      c = 32'(acc >> bits) & ((32'd1 << wid) - 32'd1);
      if (m_emitted < m_limit && cut.size() < 16) begin
        m_emitted = m_emitted + 24'd1;
        prod = 64'(c) * 64'(m_quantum);
        v = longint'($signed(m_min)) + longint'(prod);
        s.code = c[CODE_BITS-1:0];
        s.value = v[VALUE_BITS-1:0];
        s.last_of_word = 1'b0;
        s.final_sample = (m_emitted == m_limit);
        cut.push_back(s);
      end
    end
    m_carry_n = bits[CCNT_BITS-1:0];
    m_carry = 15'(acc & ((31'd1 << bits) - 31'd1));
    if (cut.size() > 0) cut[cut.size()-1].last_of_word = 1'b1;
  endtask

  // stop sending and wait for every outstanding code
  task automatic drain_results();
    word_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
  endtask

  // idle block: all codes back and any dropped-only word finished
  task automatic settle();
    drain_results();
    repeat (BLOCK_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_CODE_WIDTH: begin
        m_width   = data[WIDTH_BITS-1:0];
        m_carry   = '0;
        m_carry_n = '0;
      end
      REG_MIN_VALUE:  m_min = data;
      REG_QUANTUM:    m_quantum = data;
      REG_SAMPLE_COUNT: begin
        m_limit   = data[COUNT_BITS-1:0];
        m_emitted = '0;
        m_carry   = '0;
        m_carry_n = '0;
      end
      default: ;
    endcase
  endtask

  // one word transaction, with random idle cycles ahead of it
  task automatic send_word(input logic [WORD_BITS-1:0] w, input check_e chk,
                           input code_sample_t typed);
    code_sample_t cut[$];
    while (!calm && $urandom_range(99) < 19) begin
      word_if.valid <= 1'b0;
      @(posedge clk);
    end
    word_if.valid       <= 1'b1;
    word_if.packed_word <= w;
    @(posedge clk);
    while (!word_if.ready) @(posedge clk);
    unpack_word(w, cut);
    case (chk)
      EXP_MODEL: foreach (cut[i]) pending_samples.push_back(cut[i]);
      EXP_ONE:   pending_samples.push_back(typed);
      default: ;
    endcase
  endtask

  // result checking and random stall
  always @(posedge clk) begin : sink_check
    code_sample_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_samples.size() == 0) begin
        flag_mismatch($sformatf("unexpected code %h value %h", res_if.code, res_if.value));
      end else begin
        want = pending_samples.pop_front();
        if (res_if.code !== want.code || res_if.value !== want.value ||
            res_if.last_of_word !== want.last_of_word ||
            res_if.final_sample !== want.final_sample)
          flag_mismatch($sformatf("got %h/%h/%b/%b want %h/%h/%b/%b",
                                  res_if.code, res_if.value, res_if.last_of_word,
                                  res_if.final_sample, want.code, want.value,
                                  want.last_of_word, want.final_sample));
      end
    end
    res_if.ready <= calm || ($urandom_range(99) >= 19);
  end

  // main sequence
  initial begin : stimulus
    stim_row_t                 r;
    int unsigned               phase;
    int unsigned               words_sent;
    int unsigned               n;
    int unsigned               pick;
    logic [CFG_DATA_BITS-1:0]  d;
    rst                 = 1'b1;
    calm                = 1'b0;
    cycle_count         = 0;
    mismatches          = 0;
    word_if.valid       = 1'b0;
    word_if.packed_word = '0;
    res_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = '0;
    cfg_if.data         = '0;
    reset_copies();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.kind == ROW_REG) write_reg(r.idx, r.data);
      else send_word(r.data[WORD_BITS-1:0], r.chk, r.want);
    end

    // random phases, each with a fresh run
    phase = 0;
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      if ($urandom_range(99) < 70) begin
        pick = $urandom_range(99);
        if (pick < 4) d = 32'd0;
        else if (pick < 8) d = $urandom_range(31, 17);
        else if (pick < 10) d = $urandom;
        else d = $urandom_range(16, 1);
        write_reg(REG_CODE_WIDTH, d);
      end
      if ($urandom_range(99) < 60) begin
        pick = $urandom_range(99);
        if (pick < 10) d = 32'h8000_0000;
        else if (pick < 20) d = 32'h7FFF_FFFF;
        else if (pick < 25) d = 32'd0;
        else d = $urandom;
        write_reg(REG_MIN_VALUE, d);
      end
      if ($urandom_range(99) < 60) begin
        pick = $urandom_range(99);
        if (pick < 10) d = 32'd0;
        else if (pick < 20) d = 32'hFFFF_FFFF;
        else if (pick < 30) d = 32'd65536;
        else d = $urandom;
        write_reg(REG_QUANTUM, d);
      end
      if ($urandom_range(99) < 10)
        write_reg(8'($urandom_range(255, 4)), $urandom);
      pick = $urandom_range(99);
      if (pick < 5) d = 32'd0;
      else if (pick < 20) d = $urandom_range(24, 1);
      else if (pick < 55) d = 32'h00FF_FFFF;
      else d = $urandom_range(600, 25);
      d[31:24] = 8'($urandom);
      write_reg(REG_SAMPLE_COUNT, d);

      // one long phase runs with no random idle ahead of words and no stall
      calm <= (phase == 3);
      @(posedge clk);
      n = (phase == 3) ? 40 : $urandom_range(24, 6);
      repeat (n) begin
        if ($urandom_range(29) == 0) drain_results();
        send_word(16'($urandom), EXP_MODEL, '0);
        if (m_limit != 0) words_sent++;
      end
      calm <= 1'b0;
      phase++;
    end

    drain_results();
    repeat (BLOCK_LATENCY) @(posedge clk);
    if (mismatches == 0 && pending_samples.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
